// ===== rtl/nrt_pkg.sv =====
// Shared types and constants of the node registration table.
// Used by the channel interfaces, the table cell and the top level.
`default_nettype none

package nrt_pkg;

	// Default table depth and the largest depth the design supports.
	localparam int unsigned NRT_TABLE_ENTRIES     = 16;
	localparam int unsigned NRT_TABLE_ENTRIES_MAX = 256;

	// Widths that cover every supported depth.
	localparam int unsigned NRT_CNT_MAX_W = $clog2(NRT_TABLE_ENTRIES_MAX + 1);
	localparam int unsigned NRT_IDX_MAX_W = $clog2(NRT_TABLE_ENTRIES_MAX);

	// Payload widths.
	localparam int unsigned NRT_ID_W     = 32;
	localparam int unsigned NRT_TIME_W   = 32;
	localparam int unsigned NRT_BYTE_W   = 8;
	localparam int unsigned NRT_COUNT_W  = 5;
	localparam int unsigned NRT_CFG_IDX_W = 3;
	localparam int unsigned NRT_CFG_DAT_W = 32;

	localparam logic [NRT_BYTE_W-1:0] NRT_NO_SLOT = 8'hFF;

	// Register reset values.
	localparam logic [7:0]  NRT_RST_GATEWAY_TTL  = 8'd7;
	localparam logic [31:0] NRT_RST_EXPIRY       = 32'd3600;
	localparam logic [1:0]  NRT_RST_RELAY_TIER   = 2'd1;
	localparam logic [7:0]  NRT_RST_RELAY_BASE   = 8'd1;
	localparam logic [7:0]  NRT_RST_SLOT_LIMIT   = 8'd8;

	// Register indexes on the configuration channel.
	localparam logic [NRT_CFG_IDX_W-1:0] NRT_REG_GATEWAY_TTL = 3'd0;
	localparam logic [NRT_CFG_IDX_W-1:0] NRT_REG_EXPIRY      = 3'd1;
	localparam logic [NRT_CFG_IDX_W-1:0] NRT_REG_RELAY_TIER  = 3'd2;
	localparam logic [NRT_CFG_IDX_W-1:0] NRT_REG_RELAY_BASE  = 3'd3;
	localparam logic [NRT_CFG_IDX_W-1:0] NRT_REG_SLOT_LIMIT  = 3'd4;

	// Request kinds.
	localparam logic NRT_FUNC_SUBSCRIBE = 1'b0;
	localparam logic NRT_FUNC_TICK      = 1'b1;

	typedef enum logic [2:0] {
		NRT_ST_NEW     = 3'd0,
		NRT_ST_REREG   = 3'd1,
		NRT_ST_FULL    = 3'd2,
		NRT_ST_CLOSED  = 3'd3,
		NRT_ST_TICK    = 3'd4
	} nrt_status_t;

	// Scan token that walks the cell chain, collecting the outcome.
	typedef struct packed {
		logic                     act;
		logic                     found;
		logic [NRT_BYTE_W-1:0]    slot;
		logic [NRT_CNT_MAX_W-1:0] evicted;
		logic                     free_found;
		logic [NRT_IDX_MAX_W-1:0] free_idx;
	} nrt_tok_t;

	// Request data broadcast to every cell while a scan runs.
	typedef struct packed {
		logic                  sub_en;
		logic                  tick_en;
		logic [NRT_ID_W-1:0]   id;
		logic [NRT_TIME_W-1:0] now;
		logic [NRT_TIME_W-1:0] expiry;
	} nrt_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/nrt_if.sv =====
// Valid/ready channel interfaces of the node registration table.
// Depends on nrt_pkg for payload widths.
`default_nettype none

interface nrt_req_if
	import nrt_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic                  func;
	logic [NRT_ID_W-1:0]   node_id;
	logic [NRT_BYTE_W-1:0] capability;
	logic [NRT_BYTE_W-1:0] rx_ttl;
	logic [NRT_TIME_W-1:0] now_seconds;
	logic                  window_open;

	modport source (output valid, func, node_id, capability, rx_ttl, now_seconds,
		window_open, input ready);
	modport sink (input valid, func, node_id, capability, rx_ttl, now_seconds,
		window_open, output ready);
endinterface

interface nrt_rsp_if
	import nrt_pkg::*;
	;
	logic                   valid;
	logic                   ready;
	logic [2:0]             status;
	logic [NRT_BYTE_W-1:0]  assigned_slot;
	logic [NRT_BYTE_W-1:0]  reply_ttl;
	logic [NRT_COUNT_W-1:0] entry_count;
	logic [NRT_COUNT_W-1:0] evicted_count;

	modport source (output valid, status, assigned_slot, reply_ttl, entry_count,
		evicted_count, input ready);
	modport sink (input valid, status, assigned_slot, reply_ttl, entry_count,
		evicted_count, output ready);
endinterface

interface nrt_cfg_if
	import nrt_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic [NRT_CFG_IDX_W-1:0] index;
	logic [NRT_CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/node_registration_table_unit.sv =====
// Top level of the node registration table: a chain of entry cells and the
// request, finish and configuration logic. Depends on nrt_pkg, nrt_if and nrt_cell.
//
// Usage. Requests arrive on req: a subscribe (func 0) looks up node_id,
// refreshes a known node or stores a new one; a tick (func 1) evicts every
// entry whose age exceeds expiry_seconds. Each request yields exactly one
// response on rsp, in order. Registers are written on cfg, one index and
// one data word per request; cfg is always ready and must only be used
// while no request is outstanding.
//
// Timing. An accepted request sends a scan token down the row of
// TABLE_ENTRIES cells, one cell per cycle; the token passes the launch
// register and every cell register, and the result waits in the finish
// stage until it is loaded into the output register. The block takes one
// request at a time; the next one may be accepted the cycle after the
// response is loaded, so the length of the cell chain sets the pace.
//
// Reset empties the table and restores the register defaults at once.
// If the receiver stalls, the response is held in the output register and
// a new request may still be accepted and scanned; its result then waits
// in the finish stage until the output register is free.
`default_nettype none

module node_registration_table_unit import nrt_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = NRT_TABLE_ENTRIES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nrt_req_if.sink   req,
	nrt_rsp_if.source rsp,
	nrt_cfg_if.sink   cfg
);

	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

	// Configuration registers.
	logic [7:0]  gateway_ttl_q;
	logic [31:0] expiry_q;
	logic [1:0]  relay_tier_q;
	logic [7:0]  slot_limit_q;

	// Table-wide state.
	logic [CNT_W-1:0] count_q;
	logic [7:0]       next_relay_q;

	// Request held for the duration of its scan.
	logic                  busy_q;
	logic                  launch_q;
	logic                  func_q;
	logic [NRT_ID_W-1:0]   id_q;
	logic [1:0]            tier_q;
	logic [NRT_BYTE_W-1:0] rx_ttl_q;
	logic [NRT_TIME_W-1:0] now_q;
	logic                  win_q;

	// Finished scan waiting for the output register.
	nrt_tok_t done_q;
	logic     done_vld_q;

	// Output register.
	logic                  out_vld_q;
	nrt_status_t           status_q;
	logic [NRT_BYTE_W-1:0] slot_out_q;
	logic [NRT_BYTE_W-1:0] reply_q;
	logic [NRT_COUNT_W-1:0] count_out_q;
	logic [NRT_COUNT_W-1:0] evicted_out_q;

	nrt_tok_t tok [TABLE_ENTRIES+1];
	nrt_ctl_t ctl;
	logic [TABLE_ENTRIES-1:0] wr_en;

	logic accept;
	logic finish;
	logic insert;
	logic is_relay;
	logic [NRT_BYTE_W-1:0]  alloc_slot;
	logic [8:0]             hops;
	logic [8:0]             reply_sum;
	logic [NRT_BYTE_W-1:0]  reply;
	nrt_status_t            status_nxt;
	logic [NRT_BYTE_W-1:0]  slot_nxt;
	logic [CNT_W-1:0]       count_nxt;
	logic [NRT_CNT_MAX_W-1:0] count_wide;
	logic [NRT_CNT_MAX_W-1:0] evicted_wide;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign cfg.ready = 1'b1;

	// The first cell sees a fresh token in the cycle after acceptance, once
	// the request registers hold the new request.
	always_comb begin
		tok[0]     = '0;
		tok[0].act = launch_q;
	end

	assign ctl.sub_en  = (func_q == NRT_FUNC_SUBSCRIBE) && win_q;
	assign ctl.tick_en = (func_q == NRT_FUNC_TICK);
	assign ctl.id      = id_q;
	assign ctl.now     = now_q;
	assign ctl.expiry  = expiry_q;

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		assign wr_en[k] = insert && (done_q.free_idx == NRT_IDX_MAX_W'(k));

		nrt_cell #(
			.CELL_INDEX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1]),
			.wr_en   (wr_en[k]),
			.wr_slot (alloc_slot)
		);
	end

	// The finished scan is turned into a response as soon as the output
	// register is free or being emptied.
	assign finish = done_vld_q && (!out_vld_q || rsp.ready);

	// Hop count is the spent part of the gateway budget; the reply adds one
	// and saturates at the byte limit.
	assign hops      = (rx_ttl_q < gateway_ttl_q) ?
		({1'b0, gateway_ttl_q} - {1'b0, rx_ttl_q}) : 9'd0;
	assign reply_sum = hops + 9'd1;
	assign reply     = reply_sum[8] ? NRT_NO_SLOT : reply_sum[7:0];

	// A new node takes a relay slot only when it is relay tier and the
	// slots below the limit are not used up.
	assign is_relay   = (tier_q == relay_tier_q) && (next_relay_q < slot_limit_q);
	assign alloc_slot = is_relay ? next_relay_q : NRT_NO_SLOT;

	// A free cell was seen only if the table has room, so that flag alone
	// separates a new registration from a full table.
	assign insert = finish && (func_q == NRT_FUNC_SUBSCRIBE) && win_q &&
		!done_q.found && done_q.free_found;

	always_comb begin
		slot_nxt  = NRT_NO_SLOT;
		count_nxt = count_q;
		if (func_q == NRT_FUNC_TICK) begin
			status_nxt = NRT_ST_TICK;
			count_nxt  = count_q - done_q.evicted[CNT_W-1:0];
		end else if (!win_q) begin
			status_nxt = NRT_ST_CLOSED;
		end else if (done_q.found) begin
			status_nxt = NRT_ST_REREG;
			slot_nxt   = done_q.slot;
		end else if (!done_q.free_found) begin
			status_nxt = NRT_ST_FULL;
		end else begin
			status_nxt = NRT_ST_NEW;
			slot_nxt   = alloc_slot;
			count_nxt  = count_q + 1'b1;
		end
	end

	assign count_wide   = NRT_CNT_MAX_W'(count_nxt);
	assign evicted_wide = (func_q == NRT_FUNC_TICK) ? done_q.evicted : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			launch_q      <= 1'b0;
			done_vld_q    <= 1'b0;
			out_vld_q     <= 1'b0;
			count_q       <= '0;
			next_relay_q  <= NRT_RST_RELAY_BASE;
			gateway_ttl_q <= NRT_RST_GATEWAY_TTL;
			expiry_q      <= NRT_RST_EXPIRY;
			relay_tier_q  <= NRT_RST_RELAY_TIER;
			slot_limit_q  <= NRT_RST_SLOT_LIMIT;
		end else begin
			launch_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end

			if (tok[TABLE_ENTRIES].act) begin
				done_vld_q <= 1'b1;
			end else if (finish) begin
				done_vld_q <= 1'b0;
			end

			if (finish) begin
				out_vld_q <= 1'b1;
				count_q   <= count_nxt;
				if (insert && is_relay) begin
					next_relay_q <= next_relay_q + 8'd1;
				end
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			// The user must write registers only while the block is idle; the block itself does not enforce this.
			if (cfg.valid) begin
				unique case (cfg.index)
					NRT_REG_GATEWAY_TTL: gateway_ttl_q <= cfg.data[7:0];
					NRT_REG_EXPIRY:      expiry_q      <= cfg.data;
					NRT_REG_RELAY_TIER:  relay_tier_q  <= cfg.data[1:0];
					NRT_REG_RELAY_BASE:  next_relay_q  <= cfg.data[7:0];
					NRT_REG_SLOT_LIMIT:  slot_limit_q  <= cfg.data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			id_q     <= req.node_id;
			tier_q   <= req.capability[1:0];
			rx_ttl_q <= req.rx_ttl;
			now_q    <= req.now_seconds;
			win_q    <= req.window_open;
		end
		if (tok[TABLE_ENTRIES].act) begin
			done_q <= tok[TABLE_ENTRIES];
		end
		if (finish) begin
			status_q      <= status_nxt;
			slot_out_q    <= slot_nxt;
			reply_q       <= (func_q == NRT_FUNC_TICK) ? 8'd1 : reply;
			count_out_q   <= count_wide[NRT_COUNT_W-1:0];
			evicted_out_q <= evicted_wide[NRT_COUNT_W-1:0];
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = status_q;
	assign rsp.assigned_slot = slot_out_q;
	assign rsp.reply_ttl     = reply_q;
	assign rsp.entry_count   = count_out_q;
	assign rsp.evicted_count = evicted_out_q;

	// A scan result only exists while its request is outstanding.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_vld_q |-> busy_q)
		else $error("finished scan without an outstanding request");

	// Only one token is in flight, so a scan never lands on a held result.
	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		tok[TABLE_ENTRIES].act |-> !done_vld_q)
		else $error("scan completed while a previous result was pending");

	// The entry count never exceeds the table depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count above table depth");

	// Storing a new node grows the count by exactly one.
	a_insert_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("insert did not advance the entry count");

endmodule

`default_nettype wire

// ===== rtl/nrt_cell.sv =====
// One table cell: holds a single entry and advances the scan token by one place.
// Depends on nrt_pkg for the token and broadcast types.
`default_nettype none

module nrt_cell import nrt_pkg::*; #(
	parameter int unsigned CELL_INDEX = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire nrt_ctl_t              ctl,
	input  wire nrt_tok_t              tok_in,
	output nrt_tok_t                   tok_out,
	input  wire logic                  wr_en,
	input  wire logic [NRT_BYTE_W-1:0] wr_slot
);

	logic                  occ_q;
	logic [NRT_ID_W-1:0]   id_q;
	logic [NRT_TIME_W-1:0] last_q;
	logic [NRT_BYTE_W-1:0] slot_q;
	nrt_tok_t              tok_q;

	logic [NRT_TIME_W-1:0] age;
	logic                  hit;
	logic                  expired;
	logic                  is_free;
	nrt_tok_t              tok_nxt;

	assign age     = ctl.now - last_q;
	assign hit     = tok_in.act && occ_q && ctl.sub_en && (id_q == ctl.id);
	assign expired = tok_in.act && occ_q && ctl.tick_en && (age > ctl.expiry);
	assign is_free = tok_in.act && !occ_q && !tok_in.free_found;

	always_comb begin
		tok_nxt = tok_in;
		if (hit) begin
			tok_nxt.found = 1'b1;
			tok_nxt.slot  = slot_q;
		end
		if (expired) begin
			tok_nxt.evicted = tok_in.evicted + 1'b1;
		end
		if (is_free) begin
			tok_nxt.free_found = 1'b1;
			tok_nxt.free_idx   = NRT_IDX_MAX_W'(CELL_INDEX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (wr_en) begin
				occ_q <= 1'b1;
			end else if (expired) begin
				occ_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q   <= ctl.id;
			last_q <= ctl.now;
			slot_q <= wr_slot;
		end else if (hit) begin
			last_q <= ctl.now;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ===== test/node_registration_table_unit_tb.sv =====
// Self-checking testbench of node_registration_table_unit: a directed prelude, then
// random subscribe and tick traffic under several register settings and idle patterns.
// Depends on nrt_pkg, the channel interfaces in nrt_if and the top level of the block.
`default_nettype none

module node_registration_table_unit_tb;
	import nrt_pkg::*;

	localparam int unsigned TABLE_DEPTH    = NRT_TABLE_ENTRIES;
	localparam int unsigned ID_POOL_SIZE   = 24;
	localparam int unsigned PHASE_ITEMS    = 105;
	localparam int unsigned WATCHDOG_LIMIT = 3000;

	// One request as it travels on the request channel.
	typedef struct packed {
		logic                  func;
		logic [NRT_ID_W-1:0]   node_id;
		logic [NRT_BYTE_W-1:0] capability;
		logic [NRT_BYTE_W-1:0] rx_ttl;
		logic [NRT_TIME_W-1:0] now_seconds;
		logic                  window_open;
	} sub_req_t;

	// One response as the block should report it.
	typedef struct packed {
		nrt_status_t            status;
		logic [NRT_BYTE_W-1:0]  slot;
		logic [NRT_BYTE_W-1:0]  reply_ttl;
		logic [NRT_COUNT_W-1:0] entry_count;
		logic [NRT_COUNT_W-1:0] evicted_count;
	} sub_rsp_t;

	logic clk;
	logic arst_n;

	nrt_req_if req_ch();
	nrt_rsp_if rsp_ch();
	nrt_cfg_if cfg_ch();

	node_registration_table_unit #(
		.TABLE_ENTRIES(TABLE_DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// Shadow copy of the registration table and of the five registers.
	logic [NRT_ID_W-1:0]   reg_ids  [TABLE_DEPTH];
	logic [NRT_TIME_W-1:0] reg_seen [TABLE_DEPTH];
	logic [NRT_BYTE_W-1:0] reg_slot [TABLE_DEPTH];
	int unsigned           reg_count;
	logic [7:0]            next_relay;
	logic [7:0]            hop_budget;
	logic [31:0]           expiry_limit;
	logic [1:0]            relay_code;
	logic [7:0]            slot_base;
	logic [7:0]            slot_limit;

	// Requests waiting for the driver, and responses the block still owes us.
	sub_req_t pending_requests [$];
	sub_rsp_t awaited_results  [$];
	sub_req_t offered_req;
	bit       req_taken;

	// Stimulus shaping.
	logic [NRT_ID_W-1:0]   id_pool [ID_POOL_SIZE];
	logic [NRT_TIME_W-1:0] sim_now;
	int unsigned           time_step_max;
	int unsigned           sender_idle_pct;
	int unsigned           receiver_stall_pct;
	int unsigned           phase_count;

	// Bookkeeping.
	int unsigned requests_queued;
	int unsigned requests_sent;
	int unsigned results_checked;
	int unsigned register_writes;
	int unsigned evictions_seen;
	int unsigned status_tally [5];
	int unsigned mismatch_count;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every mismatch goes through here: one line, one count.
	task automatic log_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			log_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
		end
	endtask

	// Mirror a register write into the shadow state. A write to the relay base
	// also restarts the relay slot counter; unknown indexes change nothing.
	task automatic apply_register(input logic [NRT_CFG_IDX_W-1:0] idx, input logic [31:0] data);
		case (idx)
			NRT_REG_GATEWAY_TTL: hop_budget = data[7:0];
			NRT_REG_EXPIRY:      expiry_limit = data;
			NRT_REG_RELAY_TIER:  relay_code = data[1:0];
			NRT_REG_RELAY_BASE: begin
				slot_base  = data[7:0];
				next_relay = data[7:0];
			end
			NRT_REG_SLOT_LIMIT:  slot_limit = data[7:0];
			default: begin
			end
		endcase
	endtask

	// Compute the response to one request and advance the shadow table.
	function automatic sub_rsp_t table_outcome(input sub_req_t r);
		sub_rsp_t    res;
		int unsigned k;
		int unsigned pos;
		int unsigned hops;
		int unsigned reply;
		logic [31:0] age;
		bit          found;
		res.status        = NRT_ST_TICK;
		res.slot          = NRT_NO_SLOT;
		res.reply_ttl     = 8'd1;
		res.evicted_count = '0;
		if (r.func == NRT_FUNC_TICK) begin
			// An expired entry is overwritten by the last one, and the moved
			// entry is examined at the same position before moving on.
			k = 0;
			while (k < reg_count) begin
				age = r.now_seconds - reg_seen[k];
				if (age > expiry_limit) begin
					reg_count   = reg_count - 1;
					reg_ids[k]  = reg_ids[reg_count];
					reg_seen[k] = reg_seen[reg_count];
					reg_slot[k] = reg_slot[reg_count];
					res.evicted_count = res.evicted_count + 1'b1;
				end else begin
					k++;
				end
			end
		end else begin
			// Hop count inferred from the ttl that is left; the reply is
			// computed even when the window is closed and saturates at 255.
			hops  = (r.rx_ttl < hop_budget) ? (hop_budget - r.rx_ttl) : 0;
			reply = (hops + 1 > 255) ? 255 : hops + 1;
			res.reply_ttl = 8'(reply);
			if (!r.window_open) begin
				res.status = NRT_ST_CLOSED;
			end else begin
				found = 1'b0;
				pos   = 0;
				for (k = 0; k < reg_count; k++) begin
					if (!found && reg_ids[k] == r.node_id) begin
						found = 1'b1;
						pos   = k;
					end
				end
				if (found) begin
					reg_seen[pos] = r.now_seconds;
					res.slot      = reg_slot[pos];
					res.status    = NRT_ST_REREG;
				end else if (reg_count >= TABLE_DEPTH) begin
					res.status = NRT_ST_FULL;
				end else begin
					// Relay slots run out once the counter reaches the limit,
					// and the counter then stays where it is.
					if (r.capability[1:0] == relay_code && next_relay < slot_limit) begin
						res.slot   = next_relay;
						next_relay = next_relay + 8'd1;
					end
					reg_ids[reg_count]  = r.node_id;
					reg_seen[reg_count] = r.now_seconds;
					reg_slot[reg_count] = res.slot;
					reg_count  = reg_count + 1;
					res.status = NRT_ST_NEW;
				end
			end
		end
		res.entry_count = NRT_COUNT_W'(reg_count);
		return res;
	endfunction

	function automatic sub_req_t make_req(input logic func, input logic [31:0] id,
			input logic [7:0] cap, input logic [7:0] ttl, input logic [31:0] stamp,
			input logic win);
		sub_req_t r;
		r.func        = func;
		r.node_id     = id;
		r.capability  = cap;
		r.rx_ttl      = ttl;
		r.now_seconds = stamp;
		r.window_open = win;
		return r;
	endfunction

	// Mostly well-formed subscriptions from a small set of nodes so that the
	// table fills, refreshes and ages; the rest are ticks, closed windows,
	// unknown nodes and jumps in time.
	function automatic sub_req_t random_request();
		sub_req_t    r;
		int unsigned roll;
		roll = $urandom_range(99);
		sim_now = sim_now + $urandom_range(time_step_max);
		r.func        = NRT_FUNC_SUBSCRIBE;
		r.node_id     = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
		r.capability  = 8'($urandom);
		r.rx_ttl      = 8'($urandom);
		r.now_seconds = sim_now;
		r.window_open = 1'b1;
		if ($urandom_range(1) == 1) begin
			r.capability[1:0] = relay_code;
		end
		if ($urandom_range(1) == 1) begin
			r.rx_ttl = hop_budget + 8'($urandom_range(6)) - 8'd3;
		end
		if (roll < 12) begin
			// Ticks carry junk in the fields they ignore.
			r.func        = NRT_FUNC_TICK;
			r.window_open = 1'($urandom);
		end else if (roll < 20) begin
			r.window_open = 1'b0;
		end else if (roll < 25) begin
			r.node_id = $urandom;
		end else if (roll < 28) begin
			r.now_seconds = $urandom;
		end
		return r;
	endfunction

	task automatic queue_request(input sub_req_t r);
		pending_requests.push_back(r);
		requests_queued++;
	endtask

	// Register write on the configuration channel; the shadow copy follows
	// once the write has actually been taken.
	task automatic write_register(input logic [NRT_CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		apply_register(idx, data);
		register_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Hold the sender back until every queued request has been answered.
	task automatic wait_drained();
		while (results_checked != requests_queued) begin
			@(negedge clk);
		end
	endtask

	// New register setting and idle pattern for one phase. The block is idle
	// here, since every phase starts after a full drain. Narrow registers get
	// garbage in their unused upper bits, and one write per phase goes to an
	// index the block does not decode.
	task automatic configure_phase(input logic [7:0] gw, input logic [31:0] exp_s,
			input logic [1:0] tier, input logic [7:0] base, input logic [7:0] limit,
			input int unsigned send_pct, input int unsigned stall_pct,
			input int unsigned step);
		write_register(NRT_REG_GATEWAY_TTL, ($urandom & 32'hFFFF_FF00) | gw);
		write_register(NRT_REG_EXPIRY, exp_s);
		write_register(NRT_REG_RELAY_TIER, ($urandom & 32'hFFFF_FFFC) | tier);
		write_register(NRT_REG_RELAY_BASE, ($urandom & 32'hFFFF_FF00) | base);
		write_register(NRT_REG_SLOT_LIMIT, ($urandom & 32'hFFFF_FF00) | limit);
		write_register(NRT_REG_SLOT_LIMIT + NRT_CFG_IDX_W'(1 + phase_count % 3), $urandom);
		for (int i = 0; i < ID_POOL_SIZE; i++) begin
			id_pool[i] = $urandom;
		end
		id_pool[0]         = 32'h0000_0000;
		id_pool[1]         = 32'hFFFF_FFFF;
		sender_idle_pct    = send_pct;
		receiver_stall_pct = stall_pct;
		time_step_max      = step;
		phase_count++;
	endtask

	task automatic run_random(input int unsigned count);
		for (int i = 0; i < count; i++) begin
			queue_request(random_request());
		end
		wait_drained();
	endtask

	// Request driver: a new request is presented at a falling edge only once
	// the previous one was taken at the rising edge before it, so valid is
	// assigned exactly once per edge. The receiver's ready is randomized here too.
	always @(negedge clk) begin
		logic hold_valid;
		hold_valid = req_ch.valid && !req_taken;
		if (!hold_valid && arst_n && pending_requests.size() != 0 &&
				$urandom_range(99) >= sender_idle_pct) begin
			offered_req = pending_requests.pop_front();
			req_ch.func        <= offered_req.func;
			req_ch.node_id     <= offered_req.node_id;
			req_ch.capability  <= offered_req.capability;
			req_ch.rx_ttl      <= offered_req.rx_ttl;
			req_ch.now_seconds <= offered_req.now_seconds;
			req_ch.window_open <= offered_req.window_open;
			hold_valid = 1'b1;
		end
		req_taken = 1'b0;
		req_ch.valid <= hold_valid;
		rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// A request taken by the block is predicted at once, in acceptance order.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
			awaited_results.push_back(table_outcome(offered_req));
			req_taken = 1'b1;
			requests_sent++;
		end
	end

	// Response monitor: every taken response is matched against the oldest
	// prediction, field by field.
	always @(posedge clk) begin
		sub_rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				log_mismatch("response arrived with no request outstanding");
			end else begin
				want = awaited_results.pop_front();
				check_field("status", rsp_ch.status, want.status);
				check_field("assigned_slot", rsp_ch.assigned_slot, want.slot);
				check_field("reply_ttl", rsp_ch.reply_ttl, want.reply_ttl);
				check_field("entry_count", rsp_ch.entry_count, want.entry_count);
				check_field("evicted_count", rsp_ch.evicted_count, want.evicted_count);
				status_tally[int'(want.status)]++;
				evictions_seen += want.evicted_count;
				results_checked++;
			end
		end
	end

	// Watchdog: a long stretch without any handshake on any channel means
	// the block has hung.
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, requests_queued - results_checked);
			$display("node_registration_table_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		logic [7:0]  rnd_gw;
		logic [31:0] rnd_exp;
		int unsigned send_pct;
		int unsigned stall_pct;

		// Known values on every input from time zero, and the shadow state at
		// its reset values.
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.func        = NRT_FUNC_SUBSCRIBE;
		req_ch.node_id     = '0;
		req_ch.capability  = '0;
		req_ch.rx_ttl      = '0;
		req_ch.now_seconds = '0;
		req_ch.window_open = 1'b0;
		rsp_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		hop_budget         = NRT_RST_GATEWAY_TTL;
		expiry_limit       = NRT_RST_EXPIRY;
		relay_code         = NRT_RST_RELAY_TIER;
		slot_base          = NRT_RST_RELAY_BASE;
		slot_limit         = NRT_RST_SLOT_LIMIT;
		next_relay         = NRT_RST_RELAY_BASE;
		reg_count          = 0;
		req_taken          = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		time_step_max      = 1;
		sim_now            = '0;
		phase_count        = 0;
		requests_queued    = 0;
		requests_sent      = 0;
		results_checked    = 0;
		register_writes    = 0;
		evictions_seen     = 0;
		mismatch_count     = 0;
		idle_cycles        = 0;
		for (int i = 0; i < 5; i++) begin
			status_tally[i] = 0;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed prelude at the reset register values, with no idling.
		// A tick on an empty table evicts nothing.
		queue_request(make_req(NRT_FUNC_TICK, 32'h0, 8'h00, 8'h00, 32'd0, 1'b0));
		// First relay takes the base slot; ttl 0 gives the largest hop count.
		queue_request(make_req(NRT_FUNC_SUBSCRIBE, 32'h0, 8'h01, 8'h00, 32'd100, 1'b1));
		// Non-relay node at the top of every field gets no slot.
		queue_request(make_req(NRT_FUNC_SUBSCRIBE, 32'hFFFF_FFFF, 8'hFE, 8'hFF,
			32'hFFFF_FFFF, 1'b1));
		// Re-registration keeps the slot; ttl equal to the budget means zero hops.
		queue_request(make_req(NRT_FUNC_SUBSCRIBE, 32'h0, 8'hFF, 8'd7, 32'd200, 1'b1));
		// Closed window changes nothing but still reports the reply ttl.
		queue_request(make_req(NRT_FUNC_SUBSCRIBE, 32'h1234_5678, 8'h01, 8'd3, 32'd210, 1'b0));
		// Relays until the slot limit is reached, then relays with no slot left.
		for (int i = 0; i < 13; i++) begin
			queue_request(make_req(NRT_FUNC_SUBSCRIBE, 32'h100 + i, 8'h05, 8'd6, 32'd300 + i,
				1'b1));
		end
		// The sixteenth entry is stored with an old time so that it expires too.
		queue_request(make_req(NRT_FUNC_SUBSCRIBE, 32'hA5A5_A5A5, 8'h01, 8'd1, 32'd0, 1'b1));
		// One more node finds the table full.
		queue_request(make_req(NRT_FUNC_SUBSCRIBE, 32'h5A5A_5A5A, 8'h01, 8'd2, 32'd400, 1'b1));
		// This tick expires the first entry, then the last entry moved into its
		// place, plus the wrapped-time entry; its other fields are junk.
		queue_request(make_req(NRT_FUNC_TICK, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'd3801, 1'b0));
		wait_drained();

		// Defaults written back explicitly, no idling.
		sim_now = $urandom;
		configure_phase(8'd7, 32'd3600, 2'd1, 8'd1, 8'd8, 0, 0, 300);
		run_random(PHASE_ITEMS);

		// Largest hop budget and shortest expiry; the first request saturates
		// the reply ttl. The sender idles most of the time.
		configure_phase(8'd255, 32'd1, 2'd0, 8'd0, 8'd255, 71, 0, 2);
		queue_request(make_req(NRT_FUNC_SUBSCRIBE, $urandom, 8'h00, 8'h00, sim_now, 1'b1));
		run_random(PHASE_ITEMS);

		// Smallest budget, entries never expire, a single relay slot, and time
		// wrapping through zero. The receiver stalls most of the time.
		sim_now = 32'hFFFF_C000;
		configure_phase(8'd1, 32'hFFFF_FFFF, 2'd3, 8'd254, 8'd255, 0, 71, 1000);
		run_random(PHASE_ITEMS);

		// Relay base above the limit, so no relay slot is ever handed out.
		configure_phase(8'd128, 32'd40, 2'd2, 8'd10, 8'd1, 13, 13, 8);
		run_random(PHASE_ITEMS);

		// Random settings, walking through the idle patterns again.
		for (int p = 0; p < 4; p++) begin
			rnd_gw    = 8'($urandom_range(255, 1));
			rnd_exp   = $urandom_range(400, 20);
			send_pct  = (p % 4 == 1) ? 71 : ((p % 4 == 3) ? 13 : 0);
			stall_pct = (p % 4 == 2) ? 71 : ((p % 4 == 3) ? 13 : 0);
			configure_phase(rnd_gw, rnd_exp, 2'($urandom_range(3)),
				8'($urandom_range(254)), 8'($urandom_range(255, 1)),
				send_pct, stall_pct, rnd_exp / 8 + 1);
			run_random(PHASE_ITEMS);
		end

		// Give the block time to send anything it should not.
		repeat (TABLE_DEPTH + 8) @(negedge clk);
		if (awaited_results.size() != 0) begin
			log_mismatch($sformatf("%0d responses never arrived", awaited_results.size()));
		end

		$display("covered %0d requests in %0d register settings (%0d register writes)",
			requests_sent, phase_count + 1, register_writes);
		$display("new %0d, refreshed %0d, full %0d, window closed %0d, ticks %0d, evicted %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			status_tally[4], evictions_seen);
		if (mismatch_count == 0) begin
			$display("node_registration_table_unit_tb: PASS");
		end else begin
			$display("node_registration_table_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
